FILE: design/rie_pkg.sv
// shared types and constants for the instruction execute core
// no dependencies
package rie_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FLAG_W = 4;
    localparam int unsigned PW_W   = 17;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [4:0] SHIFT_MASK = 5'b11111;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned OFS_W  = 24;

    // instruction commands
    typedef enum logic [3:0] {
        CMD_ALU   = 4'd0,
        CMD_LSL   = 4'd1,
        CMD_ASR   = 4'd2,
        CMD_LSR   = 4'd3,
        CMD_LOAD  = 4'd4,
        CMD_LOADI = 4'd5,
        CMD_STORE = 4'd6,
        CMD_JMP   = 4'd7,
        CMD_JMPI  = 4'd8,
        CMD_JMPC  = 4'd9,
        CMD_JMPIC = 4'd10,
        CMD_BREAK = 4'd11
    } cmd_t;

    // alu operations
    typedef enum logic [2:0] {
        OP_AND = 3'd0,
        OP_OR  = 3'd1,
        OP_NOR = 3'd2,
        OP_XOR = 3'd3,
        OP_ADD = 3'd4,
        OP_SUB = 3'd5,
        OP_MUL = 3'd6,
        OP_DIV = 3'd7
    } alu_op_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PC     = 2'd1,
        ERR_OPCODE = 2'd2
    } err_t;

    // flag bit positions
    localparam int unsigned FL_ZERO  = 0;
    localparam int unsigned FL_NEG   = 1;
    localparam int unsigned FL_OVF   = 2;
    localparam int unsigned FL_CARRY = 3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MULW,
        ST_DIVW,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch instruction word
        logic read_ops;  // register operand reads
        logic execute;   // evaluate instruction
        logic mul_start;
        logic mul_fin;
        logic div_start;
        logic div_step;
        logic div_fin;
        logic commit;    // update state and output word
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic needs_mul;
        logic needs_div;
        logic div_last;
        logic clearing;  // data memory clearing pass after reset
    } dp_stat_t;

endpackage

FILE: design/rie_ctrl.sv
// controller state machine sequencing one instruction at a time
// depends on rie_pkg
module rie_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rie_pkg::dp_cmd_t  cmd,
    input  rie_pkg::dp_stat_t stat
);
    import rie_pkg::*;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid && !stat.clearing) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: begin
                if (stat.needs_div) state_next = ST_DIVW;
                else if (stat.needs_mul) state_next = ST_MULW;
                else state_next = ST_DONE;
            end
            ST_MULW: state_next = ST_DONE;
            ST_DIVW: if (stat.div_last) state_next = ST_DONE;
            ST_DONE: if (!mvalid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !stat.clearing;
                cmd.capture = s_valid && !stat.clearing;
            end
            ST_READ: cmd.read_ops = 1'b1;
            ST_EXEC: begin
                cmd.execute = 1'b1;
                cmd.mul_start = stat.needs_mul;
                cmd.div_start = stat.needs_div;
            end
            ST_MULW: cmd.mul_fin = 1'b1;
            ST_DIVW: begin
                cmd.div_step = 1'b1;
                cmd.div_fin = stat.div_last;
            end
            ST_DONE: cmd.commit = !mvalid_reg || m_ready;
            default: ;
        endcase
    end

    // output word valid
    always_comb begin
        mvalid_next = mvalid_reg;
        if (m_ready) mvalid_next = 1'b0;
        if (cmd.commit) mvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

    // a word is only committed from the done state
    a_commit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> state_reg == ST_DONE) else $error("commit outside done");
    // a committed word is valid next cycle
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid) else $error("commit lost");
    // no new word accepted while one is in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("overlapping items");
endmodule

FILE: design/rie_datapath.sv
// datapath: register file, flags, pc, data memory, multiplier and divider
// depends on rie_pkg
module rie_datapath #(
    parameter int unsigned REG_COUNT = 32,
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rie_pkg::dp_cmd_t        cmd,
    output rie_pkg::dp_stat_t       stat,
    input  logic [rie_pkg::PW_W-1:0] cfg_data,
    input  logic                    cfg_we,
    input  logic [3:0]              s_cmd,
    input  logic [4:0]              s_dest_reg,
    input  logic [4:0]              s_src_a,
    input  logic [4:0]              s_src_b,
    input  logic [2:0]              s_alu_op,
    input  logic [23:0]             s_imm,
    input  logic                    s_low_half,
    input  logic [3:0]              s_flag_select,
    output logic [31:0]             m_next_pc,
    output logic                    m_wrote_reg,
    output logic [4:0]              m_write_index,
    output logic [31:0]             m_write_value,
    output logic [3:0]              m_flags_now,
    output logic                    m_hit_break,
    output logic                    m_halted,
    output logic [1:0]              m_error_code
);
    import rie_pkg::*;

    localparam int unsigned MA_W = $clog2(MEM_WORDS);
    localparam int unsigned RI_W = $clog2(REG_COUNT);
    localparam logic [MA_W:0] CLR_END = (MA_W+1)'(MEM_WORDS);

    // captured instruction
    logic [3:0]  cmd_reg;
    logic [4:0]  rd_reg_q, ra_reg_q, rb_reg_q;
    logic [2:0]  op_reg;
    logic [23:0] imm_reg;
    logic        low_reg;
    logic [3:0]  sel_reg;

    // machine state
    logic [31:0]       pc_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [PW_W-1:0]   pw_reg;
    logic [31:0]       rf_mem [REG_COUNT];
    logic [31:0]       dmem [MEM_WORDS];
    logic [REG_COUNT-1:0] rvalid_reg;

    // memory clearing pass after reset
    logic [MA_W:0] clr_cnt_reg;
    logic          clearing;
    assign clearing = clr_cnt_reg != CLR_END;

    // operands
    logic [31:0] a_reg, b_reg, addr_reg;
    logic [31:0] mrd_reg;
    logic        mvalid_q_reg;

    // execution results
    logic [31:0] val_reg, npc_reg;
    logic        wr_reg;
    logic [FLAG_W-1:0] fl_new_reg;
    logic        fl_upd_reg, brk_reg, halt_reg;
    err_t        err_reg;

    // wide mul partials and divider
    logic [63:0] prod_reg;
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  dcnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= s_cmd;
            rd_reg_q <= s_dest_reg;
            ra_reg_q <= s_src_a;
            rb_reg_q <= s_src_b;
            op_reg   <= s_alu_op;
            imm_reg  <= s_imm;
            low_reg  <= s_low_half;
            sel_reg  <= s_flag_select;
        end
    end

    // register file read with constant registers
    function automatic logic [31:0] rd_rf(input logic [4:0] idx,
                                          input logic [31:0] data,
                                          input logic vld);
        logic [31:0] r;
        begin
            if (idx <= 5'd1) r = {27'd0, idx};
            else if ({1'b0, idx} >= 6'(REG_COUNT)) r = '0;
            else r = vld ? data : '0;
            return r;
        end
    endfunction

    logic [RI_W-1:0] ia, ib, id;
    assign ia = RI_W'(ra_reg_q);
    assign ib = RI_W'(rb_reg_q);
    assign id = RI_W'(rd_reg_q);

    // operand read stage
    always_ff @(posedge aclk) begin
        if (cmd.read_ops) begin
            a_reg    <= rd_rf(ra_reg_q, rf_mem[ia], rvalid_reg[ia]);
            b_reg    <= rd_rf(rb_reg_q, rf_mem[ib], rvalid_reg[ib]);
            addr_reg <= rd_rf(rd_reg_q, rf_mem[id], rvalid_reg[id]);
        end
    end

    // data memory read, addressed by src_a register
    logic [31:0] a_now;
    assign a_now = rd_rf(ra_reg_q, rf_mem[ia], rvalid_reg[ia]);
    always_ff @(posedge aclk) begin
        if (cmd.read_ops) begin
            mrd_reg      <= dmem[MA_W'(a_now)];
            mvalid_q_reg <= a_now < 32'(MEM_WORDS);
        end
    end

    // status
    logic gate_ok;
    assign gate_ok = (pc_reg != ALL_ONES) && ({15'd0, pw_reg} > pc_reg)
                     && (cmd_reg <= 4'(CMD_BREAK));
    assign stat.needs_mul = gate_ok && cmd_reg == CMD_ALU && op_reg == OP_MUL;
    assign stat.needs_div = gate_ok && cmd_reg == CMD_ALU && op_reg == OP_DIV;
    assign stat.div_last  = dcnt_reg == 6'd1;
    assign stat.clearing  = clearing;

    // combinational execute
    logic [31:0] sh_val, alu_r, sx, e_npc, e_val;
    logic [32:0] add_s, sub_s;
    logic [4:0]  sh;
    logic        taken, e_wr, e_brk, e_halt, e_flu;
    logic [FLAG_W-1:0] e_fl;
    err_t        e_err;

    always_comb begin
        sh = b_reg[4:0] & SHIFT_MASK;
        sx = {{8{imm_reg[OFS_W-1]}}, imm_reg};
        taken = |(sel_reg & flags_reg);
        add_s = {1'b0, a_reg} + {1'b0, b_reg};
        sub_s = {1'b0, a_reg} - {1'b0, b_reg};
        alu_r = '0;
        e_fl = '0;
        unique case (alu_op_t'(op_reg))
            OP_AND: alu_r = a_reg & b_reg;
            OP_OR:  alu_r = a_reg | b_reg;
            OP_NOR: alu_r = ~(a_reg | b_reg);
            OP_XOR: alu_r = a_reg ^ b_reg;
            OP_ADD: begin
                alu_r = add_s[31:0];
                e_fl[FL_OVF]   = (a_reg[31] ^ alu_r[31]) & (b_reg[31] ^ alu_r[31]);
                e_fl[FL_CARRY] = add_s[32];
            end
            OP_SUB: begin
                alu_r = sub_s[31:0];
                e_fl[FL_OVF]   = (a_reg[31] ^ b_reg[31]) & (a_reg[31] ^ alu_r[31]);
                e_fl[FL_CARRY] = a_reg < b_reg;
            end
            default: alu_r = '0;
        endcase
        e_fl[FL_ZERO] = alu_r == '0;
        e_fl[FL_NEG]  = alu_r[31];
        sh_val = '0;
        e_npc = pc_reg + 32'd1;
        e_val = '0;
        e_wr = 1'b0;
        e_brk = 1'b0;
        e_halt = 1'b0;
        e_flu = 1'b0;
        e_err = ERR_NONE;
        if (pc_reg == ALL_ONES) begin
            e_halt = 1'b1;
            e_npc = pc_reg;
        end else if ({15'd0, pw_reg} <= pc_reg) begin
            e_err = ERR_PC;
            e_npc = pc_reg;
        end else if (cmd_reg > 4'(CMD_BREAK)) begin
            e_err = ERR_OPCODE;
            e_npc = pc_reg;
        end else begin
            unique case (cmd_t'(cmd_reg))
                CMD_ALU: begin
                    e_val = alu_r;
                    e_wr = 1'b1;
                    e_flu = 1'b1;
                end
                CMD_LSL: begin e_val = a_reg << sh; e_wr = 1'b1; end
                CMD_ASR: begin e_val = 32'($signed(a_reg) >>> sh); e_wr = 1'b1; end
                CMD_LSR: begin e_val = a_reg >> sh; e_wr = 1'b1; end
                CMD_LOAD: begin
                    e_val = mvalid_q_reg ? mrd_reg : '0;
                    e_wr = 1'b1;
                end
                CMD_LOADI: begin
                    e_val = a_reg + (low_reg ? {16'd0, imm_reg[HALF_W-1:0]}
                                             : {imm_reg[HALF_W-1:0], 16'd0});
                    e_wr = 1'b1;
                end
                CMD_STORE: ;
                CMD_JMP:   e_npc = a_reg;
                CMD_JMPI:  e_npc = pc_reg + sx;
                CMD_JMPC:  if (taken) e_npc = a_reg;
                CMD_JMPIC: if (taken) e_npc = pc_reg + sx;
                CMD_BREAK: begin e_npc = pc_reg; e_brk = 1'b1; end
                default: ;
            endcase
        end
    end

    // execute stage registers, then mul/div finish
    logic [31:0] dtrial_rem;
    logic [32:0] dsub;
    assign dtrial_rem = {rem_reg[30:0], quo_reg[31]};
    assign dsub = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    logic signed [63:0] smul;
    logic        smul_ovf;
    logic [FLAG_W-1:0] mfl;
    logic [31:0] dres;
    assign smul = $signed(a_reg) * $signed(b_reg);
    assign smul_ovf = (smul[63:31] != '0) && (smul[63:31] != '1);
    always_comb begin
        mfl = '0;
        mfl[FL_ZERO] = prod_reg[31:0] == '0;
        mfl[FL_NEG]  = prod_reg[31];
        mfl[FL_CARRY] = prod_reg[63:32] != '0;
        mfl[FL_OVF]  = fl_new_reg[FL_OVF];
        dres = (dvs_reg == '0) ? ALL_ONES : {quo_reg[30:0], ~dsub[32]};
    end

    logic sovf_reg;
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            val_reg    <= e_val;
            npc_reg    <= e_npc;
            wr_reg     <= e_wr;
            fl_new_reg <= e_fl;
            fl_upd_reg <= e_flu;
            brk_reg    <= e_brk;
            halt_reg   <= e_halt;
            err_reg    <= e_err;
        end
        if (cmd.mul_start) begin
            prod_reg <= a_reg * b_reg;
            sovf_reg <= smul_ovf;
        end
        if (cmd.mul_fin) begin
            val_reg    <= prod_reg[31:0];
            fl_new_reg <= {mfl[FL_CARRY], sovf_reg, mfl[FL_NEG], mfl[FL_ZERO]};
        end
        // restoring divider: one quotient bit per cycle
        if (cmd.div_start) begin
            quo_reg  <= a_reg;
            rem_reg  <= '0;
            dvs_reg  <= b_reg;
            dcnt_reg <= 6'd32;
        end else if (cmd.div_step) begin
            if (!dsub[32]) rem_reg <= dsub[31:0];
            else rem_reg <= dtrial_rem;
            quo_reg  <= {quo_reg[30:0], ~dsub[32]};
            dcnt_reg <= dcnt_reg - 6'd1;
        end
        if (cmd.div_fin) begin
            val_reg <= dres;
            fl_new_reg <= {2'b00, dres[31], dres == '0};
        end
    end

    // commit: write back state and present result word
    logic do_wr;
    assign do_wr = wr_reg && rd_reg_q > 5'd1 && {1'b0, rd_reg_q} < 6'(REG_COUNT);
    logic do_st;
    assign do_st = cmd_reg == CMD_STORE && err_reg == ERR_NONE && !halt_reg
                   && addr_reg < 32'(MEM_WORDS);

    always_ff @(posedge aclk) begin
        if (cmd.commit && do_wr) rf_mem[id] <= val_reg;
        // clearing pass writes one zero word per cycle after reset
        if (clearing) dmem[clr_cnt_reg[MA_W-1:0]] <= '0;
        else if (cmd.commit && do_st) dmem[MA_W'(addr_reg)] <= a_reg;
        if (cmd.commit) begin
            m_next_pc     <= npc_reg;
            m_wrote_reg   <= do_wr;
            m_write_index <= do_wr ? rd_reg_q : 5'd0;
            m_write_value <= do_wr ? val_reg : 32'd0;
            m_flags_now   <= fl_upd_reg ? fl_new_reg : flags_reg;
            m_hit_break   <= brk_reg;
            m_halted      <= halt_reg;
            m_error_code  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            flags_reg   <= '0;
            pw_reg      <= PW_W'(65536);
            rvalid_reg  <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (clearing) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_we) pw_reg <= cfg_data;
            if (cmd.commit) begin
                pc_reg <= npc_reg;
                if (fl_upd_reg) flags_reg <= fl_new_reg;
                if (do_wr) rvalid_reg[id] <= 1'b1;
            end
        end
    end

    // divider counter only runs while stepping
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> dcnt_reg != 6'd0) else $error("divider overrun");
    // a halted pc never moves
    a_halt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && halt_reg) |-> npc_reg == pc_reg) else $error("halt moved pc");
    // flags only change on a commit
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.commit) && $past(aresetn) |-> $stable(flags_reg))
        else $error("flags changed");
endmodule

FILE: design/risc_instruction_execute_core.sv
// top level of the instruction execute core
// depends on rie_pkg, rie_ctrl, rie_datapath
// Executes one decoded instruction per input word and returns one result word.
// Items are handled one at a time: a plain instruction passes through capture,
// operand read, execute and commit, with its result word registered at commit;
// a multiply adds a multiply-finish state, and an unsigned divide adds a divide
// state repeated per quotient bit of the one-bit-per-cycle restoring divider;
// a stalled result word holds the core in its commit state. After reset the
// data memory is cleared one word per cycle, all MEM_WORDS words (4096 by
// default), with the input held off; registers 0 and 1 read as 0 and 1, others
// read as zero until written through per-register valid bits cleared at reset.
module risc_instruction_execute_core #(
    parameter int unsigned REG_COUNT = 32,
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [4:0]  s_dest_reg,
    input  logic [4:0]  s_src_a,
    input  logic [4:0]  s_src_b,
    input  logic [2:0]  s_alu_op,
    input  logic [23:0] s_imm,
    input  logic        s_low_half,
    input  logic [3:0]  s_flag_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_wrote_reg,
    output logic [4:0]  m_write_index,
    output logic [31:0] m_write_value,
    output logic [3:0]  m_flags_now,
    output logic        m_hit_break,
    output logic        m_halted,
    output logic [1:0]  m_error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    import rie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rie_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .stat
    );

    rie_datapath #(.REG_COUNT(REG_COUNT), .MEM_WORDS(MEM_WORDS)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .cfg_data, .cfg_we(cfg_valid),
        .s_cmd, .s_dest_reg, .s_src_a, .s_src_b, .s_alu_op, .s_imm,
        .s_low_half, .s_flag_select,
        .m_next_pc, .m_wrote_reg, .m_write_index, .m_write_value,
        .m_flags_now, .m_hit_break, .m_halted, .m_error_code
    );
endmodule
